### rtl/pbsg_pkg.sv
// Shared types, constants and helper functions for the piecewise Bezier setpoint generator.
// Used by every module of the block; depends on nothing else.
package pbsg_pkg;

  // Storage geometry.
  localparam int MAX_SEGMENTS = 8;
  localparam int NPTS         = 10;
  localparam int ADDR_W       = $clog2(MAX_SEGMENTS * NPTS);

  // Fixed-point geometry of the curve parameter and the divider.
  localparam int QB      = 28;
  localparam int QW      = 48;
  localparam int DW      = 36;
  localparam int XW      = 49;
  localparam logic [QB:0] Q_ONE = (QB + 1)'(1) << QB;

  // Input item codes.
  typedef enum logic [1:0] {
    MODE_POINT = 2'd0,
    MODE_DUR   = 2'd1,
    MODE_TICK  = 2'd2
  } mode_t;

  // Configuration register indexes (paddr[3:2]).
  localparam logic [1:0] REG_ENABLE   = 2'd0;
  localparam logic [1:0] REG_SEGCOUNT = 2'd1;
  localparam logic [1:0] REG_ALTITUDE = 2'd2;
  localparam logic [1:0] REG_RATE     = 2'd3;

  typedef struct packed {
    logic [1:0]         mode;
    logic [2:0]         segment_sel;
    logic [3:0]         point_sel;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [15:0]        duration_ticks;
    logic [31:0]        tick;
  } in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic signed [31:0] jerk_x;
    logic signed [31:0] jerk_y;
    logic [2:0]         segment_now;
  } out_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_ADV, ST_PREP, ST_DIVS, ST_SETS, ST_POW, ST_MT, ST_MB, ST_MA,
    ST_P0, ST_ML, ST_MH, ST_DL, ST_DV, ST_DF, ST_STORE, ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       accept;
    logic       adv;
    logic       prep;
    logic       div_load;
    logic       div_step;
    logic       fetch;
    logic       set_s;
    logic       pow;
    logic       mac_t;
    logic       mac_b;
    logic       mac_a;
    logic       acc_clr;
    logic       post0;
    logic       mul_lo;
    logic       mul_hi;
    logic       fin;
    logic       store;
    logic       diff;
    logic       out_load;
    logic [5:0] cnt;
    logic [1:0] k;
    logic [3:0] i;
  } cmd_t;

  // Binomial coefficients; row k holds degree 9-k.
  localparam logic [6:0] BINOM [0:3][0:9] = '{
    '{7'd1, 7'd9, 7'd36, 7'd84, 7'd126, 7'd126, 7'd84, 7'd36, 7'd9, 7'd1},
    '{7'd1, 7'd8, 7'd28, 7'd56, 7'd70, 7'd56, 7'd28, 7'd8, 7'd1, 7'd0},
    '{7'd1, 7'd7, 7'd21, 7'd35, 7'd35, 7'd21, 7'd7, 7'd1, 7'd0, 7'd0},
    '{7'd1, 7'd6, 7'd15, 7'd20, 7'd15, 7'd6, 7'd1, 7'd0, 7'd0, 7'd0}
  };

  // Derivative scale factors 1, 9, 9*8, 9*8*7.
  function automatic logic [8:0] dfac(input logic [1:0] k);
    logic [8:0] f;
    begin
      case (k)
        2'd0:    f = 9'd1;
        2'd1:    f = 9'd9;
        2'd2:    f = 9'd72;
        default: f = 9'd504;
      endcase
      return f;
    end
  endfunction

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [XW-1:0] v);
    logic signed [31:0] r;
    begin
      if (v > XW'(64'sh7FFF_FFFF)) begin
        r = 32'sh7FFF_FFFF;
      end else if (v < -XW'(64'sh8000_0000)) begin
        r = 32'sh8000_0000;
      end else begin
        r = v[31:0];
      end
      return r;
    end
  endfunction

  // Next segment index, (cur + 1) modulo the clipped segment count.
  function automatic logic [2:0] next_seg(input logic [2:0] cur, input logic [3:0] scount);
    logic [3:0] c;
    logic [3:0] v;
    begin
      if (scount == 4'd0) begin
        c = 4'd1;
      end else if (scount > 4'(MAX_SEGMENTS)) begin
        c = 4'(MAX_SEGMENTS);
      end else begin
        c = scount;
      end
      v = {1'b0, cur} + 4'd1;
      for (int n = 0; n < MAX_SEGMENTS; n++) begin
        if (v >= c) begin
          v = v - c;
        end
      end
      return v[2:0];
    end
  endfunction

endpackage

### rtl/piecewise_bezier_setpoint_generator_top.sv
// Top level: APB configuration registers and the controller/datapath pair.
// Depends on pbsg_pkg, pbsg_ctrl, pbsg_dp and pbsg_div.
//
// Write transactions (control point or duration) are accepted in the idle state and
// return no result. A tick transaction first checks the segment and returns to
// idle when output is disabled; when enabled it divides for the curve parameter,
// runs the basis multiply-accumulate over the four derivative orders, and then
// six scaling stages, each a multiply and a bit-serial divide with a 48-bit
// quotient. A finished setpoint sits in the output register, so the next item
// is taken while it waits. Control points and durations are undefined until
// they have been written.
module piecewise_bezier_setpoint_generator_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  pbsg_pkg::in_t     in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output pbsg_pkg::out_t    out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import pbsg_pkg::*;

  logic               traj_enable;
  logic [3:0]         segment_count;
  logic signed [31:0] altitude;
  logic [15:0]        tick_rate_hz;
  logic               cfg_we;
  cmd_t               cmd;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      traj_enable   <= 1'b0;
      segment_count <= 4'd5;
      altitude      <= 32'sd131072;
      tick_rate_hz  <= 16'd500;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_ENABLE:   traj_enable   <= pwdata[0];
        REG_SEGCOUNT: segment_count <= pwdata[3:0];
        REG_ALTITUDE: altitude      <= pwdata;
        REG_RATE:     tick_rate_hz  <= pwdata[15:0];
        default:      traj_enable   <= traj_enable;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (paddr[3:2])
      REG_ENABLE:   prdata = {31'd0, traj_enable};
      REG_SEGCOUNT: prdata = {28'd0, segment_count};
      REG_ALTITUDE: prdata = altitude;
      REG_RATE:     prdata = {16'd0, tick_rate_hz};
      default:      prdata = 32'd0;
    endcase
  end

  pbsg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_mode   (in_data.mode),
    .enable    (traj_enable),
    .out_ready (out_ready),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  pbsg_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .in_data       (in_data),
    .segment_count (segment_count),
    .tick_rate_hz  (tick_rate_hz),
    .altitude      (altitude),
    .out_data      (out_data)
  );

endmodule

### rtl/pbsg_div.sv
// Bit-serial restoring divider: one quotient bit per step, 16-bit divisor.
// Depends on pbsg_pkg for the quotient width.
module pbsg_div (
  input  logic                  clk,
  input  logic                  load,
  input  logic                  step,
  input  logic [15:0]           rem_init,
  input  logic [pbsg_pkg::QW-1:0] num_init,
  input  logic [15:0]           dur,
  output logic [15:0]           rem,
  output logic [pbsg_pkg::QW-1:0] quo
);
  import pbsg_pkg::*;

  logic [16:0] r2;
  logic        ge;
  logic [16:0] diff;

  // Trial subtraction of the divisor from the shifted remainder.
  assign r2   = {rem, quo[QW-1]};
  assign ge   = r2 >= {1'b0, dur};
  assign diff = r2 - {1'b0, dur};

  // Numerator bits shift out of quo while quotient bits shift in.
  always_ff @(posedge clk) begin
    if (load) begin
      rem <= rem_init;
      quo <= num_init;
    end else if (step) begin
      rem <= ge ? diff[15:0] : r2[15:0];
      quo <= {quo[QW-2:0], ge};
    end
  end

endmodule

### rtl/pbsg_dp.sv
// Datapath: control point and duration storage, segment timing, Bernstein basis,
// derivative accumulation and scaling. Depends on pbsg_pkg and pbsg_div.
module pbsg_dp (
  input  logic                clk,
  input  logic                rst,
  input  pbsg_pkg::cmd_t      cmd,
  input  pbsg_pkg::in_t       in_data,
  input  logic [3:0]          segment_count,
  input  logic [15:0]         tick_rate_hz,
  input  logic signed [31:0]  altitude,
  output pbsg_pkg::out_t      out_data
);
  import pbsg_pkg::*;

  logic signed [31:0] mem_x [0:MAX_SEGMENTS*NPTS-1];
  logic signed [31:0] mem_y [0:MAX_SEGMENTS*NPTS-1];
  logic signed [31:0] rd_x, rd_y;
  logic [15:0]        dur_mem [0:MAX_SEGMENTS-1];
  logic [ADDR_W-1:0]  wr_addr, rd_addr;
  logic               mem_we;

  logic [2:0]  cur;
  logic [31:0] start_tick, tick_q, e;
  logic [15:0] e_r, dur_r, dur0, rate;

  logic signed [DW-1:0] dx [0:NPTS-1];
  logic signed [DW-1:0] dy [0:NPTS-1];
  logic [QB:0] sp [0:NPTS-1];
  logic [QB:0] up [0:NPTS-1];
  logic [QB:0] sp_last, up_last, s_r, u_r, t_r, b_r;
  logic [2*QB+1:0] p_s, p_u, p_t;
  logic [35:0]     p_b;
  logic [3:0]      nn;

  logic signed [63:0] acc_x, acc_y;
  logic signed [65:0] mac_x, mac_y;
  logic signed [DW-1:0] fl_x, fl_y;
  logic signed [XW-1:0] p0_x, p0_y, x_x, x_y, mag_x, mag_y;
  logic [39:0] lo_x, lo_y, hi_x, hi_y;
  logic [63:0] prod_x, prod_y;
  logic        neg_x, neg_y, ovf_x, ovf_y;
  logic [XW-1:0] qa_x, qa_y, mc_x, mc_y;
  logic signed [31:0] res_x [0:3];
  logic signed [31:0] res_y [0:3];

  logic [15:0]   rem_x, rem_y, rem_init_x;
  logic [QW-1:0] quo_x, quo_y, num_init_x;

  localparam logic [XW-1:0] LIM = XW'(1) << (XW - 2);

  // Table addressing.
  assign wr_addr = ADDR_W'(in_data.segment_sel) * ADDR_W'(NPTS) + ADDR_W'(in_data.point_sel);
  assign rd_addr = ADDR_W'(cur) * ADDR_W'(NPTS) +
                   ((cmd.cnt < 6'(NPTS)) ? ADDR_W'(cmd.cnt) : ADDR_W'(0));
  assign mem_we  = cmd.accept && (in_data.mode == MODE_POINT) &&
                   (in_data.point_sel < 4'(NPTS));

  // Control point memories with registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_x[wr_addr] <= in_data.point_x;
      mem_y[wr_addr] <= in_data.point_y;
    end
    rd_x <= mem_x[rd_addr];
    rd_y <= mem_y[rd_addr];
  end

  // Duration table.
  always_ff @(posedge clk) begin
    if (cmd.accept && (in_data.mode == MODE_DUR)) begin
      dur_mem[in_data.segment_sel] <= in_data.duration_ticks;
    end
  end

  // Elapsed time against the current segment's duration, zero meaning one.
  assign e    = tick_q - start_tick;
  assign dur0 = (dur_mem[cur] == 16'd0) ? 16'd1 : dur_mem[cur];
  assign rate = (tick_rate_hz == 16'd0) ? 16'd1 : tick_rate_hz;

  // Segment sequencing state.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur        <= 3'd0;
      start_tick <= 32'd0;
    end else if (cmd.adv && (e >= {16'd0, dur0})) begin
      cur        <= next_seg(cur, segment_count);
      start_tick <= tick_q;
    end
  end

  // Tick capture, elapsed count and active duration.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      tick_q <= in_data.tick;
    end
    if (cmd.adv) begin
      e_r <= (e >= {16'd0, dur0}) ? 16'd0 : e[15:0];
    end
    if (cmd.prep) begin
      dur_r <= dur0;
    end
  end

  // The x divider also produces the curve parameter.
  assign rem_init_x = cmd.prep ? e_r : prod_x[63:QW];
  assign num_init_x = cmd.prep ? QW'(0) : prod_x[QW-1:0];

  pbsg_div u_div_x (
    .clk      (clk),
    .load     (cmd.prep || cmd.div_load),
    .step     (cmd.div_step),
    .rem_init (rem_init_x),
    .num_init (num_init_x),
    .dur      (dur_r),
    .rem      (rem_x),
    .quo      (quo_x)
  );

  pbsg_div u_div_y (
    .clk      (clk),
    .load     (cmd.div_load),
    .step     (cmd.div_step),
    .rem_init (prod_y[63:QW]),
    .num_init (prod_y[QW-1:0]),
    .dur      (dur_r),
    .rem      (rem_y),
    .quo      (quo_y)
  );

  // Power chains of S and U, and the basis product for the current term.
  assign p_s = sp_last * s_r;
  assign p_u = up_last * u_r;
  assign nn  = 4'(NPTS - 1) - {2'b00, cmd.k};
  assign p_t = sp[cmd.i] * up[nn - cmd.i];
  assign p_b = t_r * BINOM[cmd.k][cmd.i];

  always_ff @(posedge clk) begin
    if (cmd.set_s) begin
      s_r     <= {1'b0, quo_x[QB-1:0]};
      u_r     <= Q_ONE - {1'b0, quo_x[QB-1:0]};
      sp[0]   <= Q_ONE;
      up[0]   <= Q_ONE;
      sp_last <= Q_ONE;
      up_last <= Q_ONE;
    end
    if (cmd.pow) begin
      sp[cmd.cnt[3:0]] <= p_s[2*QB:QB];
      up[cmd.cnt[3:0]] <= p_u[2*QB:QB];
      sp_last          <= p_s[2*QB:QB];
      up_last          <= p_u[2*QB:QB];
    end
    if (cmd.mac_t) begin
      t_r <= p_t[2*QB:QB];
    end
    if (cmd.mac_b) begin
      b_r <= p_b[QB:0];
    end
  end

  // Point registers: filled from memory, then forward-differenced per derivative.
  always_ff @(posedge clk) begin
    if (cmd.fetch && (cmd.cnt >= 6'd1) && (cmd.cnt <= 6'(NPTS))) begin
      dx[4'(cmd.cnt - 6'd1)] <= DW'(rd_x);
      dy[4'(cmd.cnt - 6'd1)] <= DW'(rd_y);
    end else if (cmd.diff) begin
      for (int n = 0; n < NPTS - 1; n++) begin
        dx[n] <= dx[n + 1] - dx[n];
        dy[n] <= dy[n + 1] - dy[n];
      end
    end
  end

  // Weighted sum of differenced points.
  assign mac_x = $signed({1'b0, b_r}) * dx[cmd.i];
  assign mac_y = $signed({1'b0, b_r}) * dy[cmd.i];

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      acc_x <= 64'sd0;
      acc_y <= 64'sd0;
    end else if (cmd.mac_a) begin
      acc_x <= acc_x + $signed(mac_x[63:0]);
      acc_y <= acc_y + $signed(mac_y[63:0]);
    end
  end

  // Floor to Q0 of the curve sum and scale by the derivative factor.
  assign fl_x = DW'(acc_x >>> QB);
  assign fl_y = DW'(acc_y >>> QB);
  assign p0_x = fl_x * $signed({1'b0, dfac(cmd.k)});
  assign p0_y = fl_y * $signed({1'b0, dfac(cmd.k)});

  // Magnitude times rate, computed as a low and then a high partial product.
  assign mag_x = x_x[XW-1] ? -x_x : x_x;
  assign mag_y = x_y[XW-1] ? -x_y : x_y;
  assign lo_x  = mag_x[23:0] * rate;
  assign lo_y  = mag_y[23:0] * rate;
  assign hi_x  = mag_x[47:24] * rate;
  assign hi_y  = mag_y[47:24] * rate;

  // Floor division result, clamped to plus or minus 2^47.
  assign qa_x = {1'b0, quo_x} + XW'(neg_x && (rem_x != 16'd0));
  assign qa_y = {1'b0, quo_y} + XW'(neg_y && (rem_y != 16'd0));
  assign mc_x = (ovf_x || (qa_x > LIM)) ? LIM : qa_x;
  assign mc_y = (ovf_y || (qa_y > LIM)) ? LIM : qa_y;

  always_ff @(posedge clk) begin
    if (cmd.post0) begin
      x_x <= p0_x;
      x_y <= p0_y;
    end else if (cmd.fin) begin
      x_x <= neg_x ? -$signed(mc_x) : $signed(mc_x);
      x_y <= neg_y ? -$signed(mc_y) : $signed(mc_y);
    end
    if (cmd.mul_lo) begin
      prod_x <= 64'(lo_x);
      prod_y <= 64'(lo_y);
      neg_x  <= x_x[XW-1];
      neg_y  <= x_y[XW-1];
    end else if (cmd.mul_hi) begin
      prod_x <= prod_x + {hi_x, 24'd0};
      prod_y <= prod_y + {hi_y, 24'd0};
    end
    if (cmd.div_load) begin
      ovf_x <= prod_x[63:QW] >= dur_r;
      ovf_y <= prod_y[63:QW] >= dur_r;
    end
    if (cmd.store) begin
      res_x[cmd.k] <= sat32(x_x);
      res_y[cmd.k] <= sat32(x_y);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.pos_x       <= res_x[0];
      out_data.pos_y       <= res_y[0];
      out_data.pos_z       <= altitude;
      out_data.vel_x       <= res_x[1];
      out_data.vel_y       <= res_y[1];
      out_data.acc_x       <= res_x[2];
      out_data.acc_y       <= res_y[2];
      out_data.jerk_x      <= res_x[3];
      out_data.jerk_y      <= res_y[3];
      out_data.segment_now <= cur;
    end
  end

endmodule

### rtl/pbsg_ctrl.sv
// Controller: sequences write items and the tick evaluation, drives the datapath.
// Depends on pbsg_pkg for the state, command and mode types.
module pbsg_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [1:0]     in_mode,
  input  logic           enable,
  input  logic           out_ready,
  output logic           in_ready,
  output logic           out_valid,
  output pbsg_pkg::cmd_t cmd
);
  import pbsg_pkg::*;

  state_t     state, state_next;
  logic [5:0] cnt, cnt_next;
  logic [1:0] k, k_next, j, j_next;
  logic [3:0] i, i_next, last_i;
  logic       out_valid_next;

  assign last_i = 4'(NPTS - 1) - {2'b00, k};

  // State and counter registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= 6'd0;
      k         <= 2'd0;
      j         <= 2'd0;
      i         <= 4'd0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      k         <= k_next;
      j         <= j_next;
      i         <= i_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    k_next         = k;
    j_next         = j;
    i_next         = i;
    out_valid_next = out_valid && !out_ready;
    in_ready       = (state == ST_IDLE);
    cmd            = '0;
    cmd.cnt        = cnt;
    cmd.k          = k;
    cmd.i          = i;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_mode == MODE_TICK) begin
            state_next = ST_ADV;
          end
        end
      end
      ST_ADV: begin
        cmd.adv    = 1'b1;
        state_next = ST_PREP;
      end
      ST_PREP: begin
        cmd.prep = 1'b1;
        cnt_next = 6'd0;
        state_next = enable ? ST_DIVS : ST_IDLE;
      end
      ST_DIVS: begin
        cmd.div_step = 1'b1;
        cmd.fetch    = 1'b1;
        if (cnt == 6'(QB - 1)) begin
          state_next = ST_SETS;
        end else begin
          cnt_next = cnt + 6'd1;
        end
      end
      ST_SETS: begin
        cmd.set_s   = 1'b1;
        cmd.acc_clr = 1'b1;
        cnt_next    = 6'd1;
        state_next  = ST_POW;
      end
      ST_POW: begin
        cmd.pow = 1'b1;
        if (cnt == 6'(NPTS - 1)) begin
          k_next     = 2'd0;
          i_next     = 4'd0;
          state_next = ST_MT;
        end else begin
          cnt_next = cnt + 6'd1;
        end
      end
      ST_MT: begin
        cmd.mac_t  = 1'b1;
        state_next = ST_MB;
      end
      ST_MB: begin
        cmd.mac_b  = 1'b1;
        state_next = ST_MA;
      end
      ST_MA: begin
        cmd.mac_a = 1'b1;
        if (i == last_i) begin
          state_next = ST_P0;
        end else begin
          i_next     = i + 4'd1;
          state_next = ST_MT;
        end
      end
      ST_P0: begin
        cmd.post0  = 1'b1;
        j_next     = 2'd0;
        state_next = (k == 2'd0) ? ST_STORE : ST_ML;
      end
      ST_ML: begin
        cmd.mul_lo = 1'b1;
        state_next = ST_MH;
      end
      ST_MH: begin
        cmd.mul_hi = 1'b1;
        state_next = ST_DL;
      end
      ST_DL: begin
        cmd.div_load = 1'b1;
        cnt_next     = 6'd0;
        state_next   = ST_DV;
      end
      ST_DV: begin
        cmd.div_step = 1'b1;
        if (cnt == 6'(QW - 1)) begin
          state_next = ST_DF;
        end else begin
          cnt_next = cnt + 6'd1;
        end
      end
      ST_DF: begin
        cmd.fin    = 1'b1;
        j_next     = j + 2'd1;
        state_next = ((j + 2'd1) == k) ? ST_STORE : ST_ML;
      end
      ST_STORE: begin
        cmd.store = 1'b1;
        if (k == 2'd3) begin
          state_next = ST_OUT;
        end else begin
          cmd.diff    = 1'b1;
          cmd.acc_clr = 1'b1;
          k_next      = k + 2'd1;
          i_next      = 4'd0;
          state_next  = ST_MT;
        end
      end
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // A tick transaction always starts the segment check next.
  a_tick_start: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && (in_mode == MODE_TICK)) |=> (state == ST_ADV))
    else $error("tick transaction did not start evaluation");

  // The output register is only loaded when its previous result is gone.
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result overwritten before transfer");

  // Basis index stays within the degree of the current derivative.
  a_mac_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MA) |-> (i <= last_i))
    else $error("basis index out of range");

  // Scaling stages run only for derivatives, with the stage index below the derivative order.
  a_scale_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ML) |-> (j < k))
    else $error("too many scaling stages");
`endif

endmodule
